### hdl/quaternion_to_euler_defines.svh
// assertion helper macros for the quaternion to euler block
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// property that must hold on every edge outside reset
`define Q2E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// constants, cell payload type and helper functions for the converter
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int TABLE_LEN        = 24;
  localparam int QW               = 16;
  // cordic datapath width: operands normalized to >= 2^40, growth < 2 bits
  localparam int DW               = 46;
  localparam int ZW               = 34;
  localparam int SQW              = 58;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [DW-1:0] ONE_Q28     = 46'sd268435456;

  // vectoring cordic payload handed from cell to cell
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 34'sd843314857;
        1: r = 34'sd497837830;
        2: r = 34'sd263043837;
        3: r = 34'sd133525159;
        4: r = 34'sd67021687;
        5: r = 34'sd33543516;
        6: r = 34'sd16775851;
        7: r = 34'sd8388437;
        8: r = 34'sd4194283;
        9: r = 34'sd2097149;
        default: r = ZW'(64'sd1 <<< (30 - i));
      endcase
      return r;
    end
  endfunction

endpackage

### hdl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// one registered vectoring cordic micro-rotation
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  q2e_pkg::cordic_t  din,
  output q2e_pkg::cordic_t  dout
);
  q2e_pkg::cordic_t nxt;
  logic signed [q2e_pkg::DW-1:0] dx, dy;

  always_comb begin
    dx  = din.x >>> STEP;
    dy  = din.y >>> STEP;
    nxt = din;
    if (STEP < q2e_pkg::TABLE_LEN) begin
      if (din.y > 0) begin
        nxt.x = din.x + dy;
        nxt.y = din.y - dx;
        nxt.z = din.z + q2e_pkg::atan_q30(STEP);
      end else if (din.y < 0) begin
        nxt.x = din.x - dy;
        nxt.y = din.y + dx;
        nxt.z = din.z - q2e_pkg::atan_q30(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

### hdl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// one registered restoring square root step, two radicand bits per cell
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [q2e_pkg::SQW-1:0]   rem_in,
  input  logic [q2e_pkg::SQW-1:0]   res_in,
  output logic [q2e_pkg::SQW-1:0]   rem_out,
  output logic [q2e_pkg::SQW-1:0]   res_out
);
  localparam logic [q2e_pkg::SQW-1:0] BIT = q2e_pkg::SQW'(1) << (56 - 2 * STEP);
  logic [q2e_pkg::SQW-1:0] trial;

  always_comb trial = res_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        res_out <= (res_in >> 1) + BIT;
      end else begin
        rem_out <= rem_in;
        res_out <= res_in >> 1;
      end
    end
  end
endmodule

### hdl/q2e_atan2.sv
// ----------------------------------------------------------------------------
// q2e_atan2
// normalize, pre-rotate, then a chain of cordic cells; output in Q30 rad
// ----------------------------------------------------------------------------
module q2e_atan2 #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [q2e_pkg::DW-1:0]   y_in,
  input  logic signed [q2e_pkg::DW-1:0]   x_in,
  output logic signed [q2e_pkg::ZW-1:0]   z_out
);
  localparam int NS = (CORDIC_STEPS < q2e_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                         : q2e_pkg::TABLE_LEN;
  q2e_pkg::cordic_t chain [NS+1];
  q2e_pkg::cordic_t pre;
  logic [q2e_pkg::DW-1:0] ax, ay, mx;
  logic [5:0] lz;
  logic signed [q2e_pkg::DW-1:0] nx, ny;

  // normalize so the larger magnitude reaches bit 40 (operands fit below 2^41)
  always_comb begin
    ax = x_in[q2e_pkg::DW-1] ? q2e_pkg::DW'(-x_in) : q2e_pkg::DW'(x_in);
    ay = y_in[q2e_pkg::DW-1] ? q2e_pkg::DW'(-y_in) : q2e_pkg::DW'(y_in);
    mx = ax | ay;
    lz = '0;
    for (int b = 0; b <= 40; b++) begin
      if (mx[b]) lz = 6'(40 - b);
    end
    if (mx == '0) lz = '0;
    nx = x_in <<< lz;
    ny = y_in <<< lz;
    pre.x = nx;
    pre.y = ny;
    pre.z = '0;
    if (nx < 0) begin
      if (ny >= 0) begin
        pre.x = ny; pre.y = -nx; pre.z = q2e_pkg::HALF_PI_Q30;
      end else begin
        pre.x = -ny; pre.y = nx; pre.z = -q2e_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) chain[0] <= pre;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cell
    q2e_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign z_out = chain[NS].z;
endmodule

### hdl/quaternion_to_euler.sv
// data reaches the output register through a pipeline of 3 operand stages, 29 square
// root cells and CORDIC_STEPS + 1 cordic stages, the first stage loaded at the
// accepting edge; steps capped at 24
// throughput: one transaction per cycle; the pipeline stalls as a whole only when
// the output register is full and not taken
// reset clears the stage valid bits and out_valid only; datapath registers need no reset
// ----------------------------------------------------------------------------
// quaternion_to_euler
// quaternion Q2.14 to roll/pitch/yaw in Q3.13 radians via cordic cell chains
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_defines.svh"
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_WIDTH  = q2e_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  input  logic signed [15:0]       quat_w,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       angle_x,
  output logic signed [15:0]       angle_y,
  output logic signed [15:0]       angle_z,
  output logic                     gimbal_clamped
);
  localparam int DW   = q2e_pkg::DW;
  localparam int ZW   = q2e_pkg::ZW;
  localparam int SQW  = q2e_pkg::SQW;
  localparam int NS   = (CORDIC_STEPS < q2e_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                           : q2e_pkg::TABLE_LEN;
  localparam int SQN  = 29;                 // square root cells, 2 bits each
  localparam int PRE  = 3;                  // product, sum and square stages
  localparam int CLAT = NS + 1;             // atan2 block latency
  localparam int DEP  = PRE + SQN + CLAT;   // stages before output register
  localparam int OSH  = 33 - ANGLE_WIDTH;

  // whole pipeline advances when the output register can take data
  logic en;
  logic [DEP-1:0] vld;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEP-2:0], in_valid};
    end
  end

  // stage 1: the nine products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;  p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;  p_yy <= quat_y * quat_y;
      p_wz <= quat_w * quat_z;  p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;  p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
    end
  end

  // stage 2: operands in units of 2^-28
  logic signed [DW-1:0] sx, cx, sz, cz, sp;
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= (DW'(p_wx) + DW'(p_yz)) <<< 1;
      cx <= q2e_pkg::ONE_Q28 - ((DW'(p_xx) + DW'(p_yy)) <<< 1);
      sz <= (DW'(p_wz) + DW'(p_xy)) <<< 1;
      cz <= q2e_pkg::ONE_Q28 - ((DW'(p_yy) + DW'(p_zz)) <<< 1);
      sp <= (DW'(p_wy) - DW'(p_zx)) <<< 1;
    end
  end

  // stage 3: pitch clamp decision and radicand 2^56 - sp^2
  logic signed [DW-1:0] sp3;
  logic                 clamp3;
  logic [SQW-1:0]       rad3;
  logic [DW-1:0]        asp;
  logic [29:0]          asq;
  logic [59:0]          asq2;
  assign asp  = sp[DW-1] ? DW'(-sp) : DW'(sp);
  assign asq  = asp[29:0];
  // 30 by 30 square, only meaningful when the clamp is not taken
  assign asq2 = {30'b0, asq} * {30'b0, asq};
  always_ff @(posedge clk) begin
    if (en) begin
      sp3    <= sp;
      clamp3 <= asp >= DW'(q2e_pkg::ONE_Q28);
      rad3   <= (SQW'(1) << 56) - SQW'(asq2);
    end
  end

  // square root cell chain, pitch operands carried alongside
  logic [SQW-1:0]       rem [SQN+1];
  logic [SQW-1:0]       res [SQN+1];
  logic signed [DW-1:0] spd [SQN+1];
  logic                 cld [SQN+1];
  assign rem[0] = rad3;
  assign res[0] = '0;
  assign spd[0] = sp3;
  assign cld[0] = clamp3;
  for (genvar i = 0; i < SQN; i++) begin : g_sq
    q2e_sqrt_cell #(.STEP(i)) u_sq (
      .clk(clk), .en(en), .rem_in(rem[i]), .res_in(res[i]),
      .rem_out(rem[i+1]), .res_out(res[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        spd[i+1] <= spd[i];
        cld[i+1] <= cld[i];
      end
    end
  end

  // roll and yaw operands delayed to line up with the pitch cordic
  logic signed [DW-1:0] sxd [SQN+1], cxd [SQN+1], szd [SQN+1], czd [SQN+1];
  always_ff @(posedge clk) begin
    if (en) begin
      sxd[0] <= sx; cxd[0] <= cx; szd[0] <= sz; czd[0] <= cz;
      for (int i = 0; i < SQN; i++) begin
        sxd[i+1] <= sxd[i]; cxd[i+1] <= cxd[i];
        szd[i+1] <= szd[i]; czd[i+1] <= czd[i];
      end
    end
  end

  logic signed [ZW-1:0] zx, zy, zz;
  q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .y_in(sxd[SQN]), .x_in(cxd[SQN]), .z_out(zx)
  );
  q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .y_in(szd[SQN]), .x_in(czd[SQN]), .z_out(zz)
  );
  q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .y_in(spd[SQN]), .x_in(DW'(res[SQN])), .z_out(zy)
  );

  // clamp flag delayed through the pitch cordic
  logic cl_d [CLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      cl_d[0] <= cld[SQN];
      for (int i = 1; i < CLAT; i++) cl_d[i] <= cl_d[i-1];
    end
  end

  // round half up to the output unit and saturate to +-pi
  function automatic logic [15:0] to_out(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] r, lim;
    begin
      lim = ((ZW+1)'(q2e_pkg::PI_Q30) + ((ZW+1)'(1) <<< (OSH-1))) >>> OSH;
      r   = ((ZW+1)'(z) + ((ZW+1)'(1) <<< (OSH-1))) >>> OSH;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
    end
  endfunction

  // pitch argument carried alongside the pitch cordic for the clamp sign
  logic signed [DW-1:0] sp_sign_d [CLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sp_sign_d[0] <= spd[SQN];
      for (int i = 1; i < CLAT; i++) sp_sign_d[i] <= sp_sign_d[i-1];
    end
  end

  logic signed [ZW-1:0] zy_sel;
  assign zy_sel = cl_d[CLAT-1] ? (sp_sign_d[CLAT-1][DW-1] ? -q2e_pkg::HALF_PI_Q30
                                                          : q2e_pkg::HALF_PI_Q30) : zy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_x        <= to_out(zx);
      angle_z        <= to_out(zz);
      angle_y        <= cl_d[CLAT-1]
                        ? to_out(sp_sign_d[CLAT-1][DW-1] ? -q2e_pkg::HALF_PI_Q30
                                                         : q2e_pkg::HALF_PI_Q30)
                        : to_out(zy);
      gimbal_clamped <= cl_d[CLAT-1];
    end
  end

  // zy_sel kept for the clamp check below
  `Q2E_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready),
              "input ready does not follow output register state")
  `Q2E_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid,
                   "result dropped while stalled")
  `Q2E_ASSERT_NEXT(a_fill, en && vld[DEP-1], out_valid,
                   "pipeline valid lost at output")
  `Q2E_ASSERT(a_clamp_range, !(en && vld[DEP-1] && cl_d[CLAT-1])
              || zy_sel == q2e_pkg::HALF_PI_Q30
              || zy_sel == -q2e_pkg::HALF_PI_Q30, "clamped pitch not at half pi")
endmodule
